// File: hdl/deq_pkg.sv
package deq_pkg;

   // Operation codes carried by an input item.
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_WALK_FWD   = 3'd2;
   localparam logic [2:0] OP_WALK_BWD   = 3'd3;
   localparam logic [2:0] OP_POP_FRONT  = 3'd4;
   localparam logic [2:0] OP_POP_BACK   = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int OpWidth     = 3;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   push_front;
      logic                   push_back;
      logic                   pop_front;
      logic                   pop_back;
      logic                   walk_start;
      logic                   walk_back;
      logic                   walk_read;
      logic                   walk_emit;
      logic                   emit_status;
      logic [StatusWidth-1:0] status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic empty;
      logic full;
      logic walk_last;
   } dp_sts_type;

endpackage

// File: hdl/deq_ctrl.sv
module deq_ctrl
   import deq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [OpWidth-1:0] req_opcode,
   output logic               req_tready,
   output dp_cmd_type         cmd,
   input  dp_sts_type         sts
);

   localparam logic [1:0] S_IDLE      = 2'd0;
   localparam logic [1:0] S_WALK_RD   = 2'd1;
   localparam logic [1:0] S_WALK_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     cmd.emit_status = 1'b1;
                     if (sts.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.status     = ST_OK;
                        cmd.push_front = (req_opcode == OP_PUSH_FRONT);
                        cmd.push_back  = (req_opcode == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     cmd.emit_status = 1'b1;
                     if (sts.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.status    = ST_OK;
                        cmd.pop_front = (req_opcode == OP_POP_FRONT);
                        cmd.pop_back  = (req_opcode == OP_POP_BACK);
                     end
                  end
                  OP_WALK_FWD, OP_WALK_BWD: begin
                     if (sts.empty) begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = ST_EMPTY;
                     end else begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_back  = (req_opcode == OP_WALK_BWD);
                        state_in       = S_WALK_RD;
                     end
                  end
                  default: begin
                     // Unused codes are taken and dropped without a result.
                  end
               endcase
            end
         end
         S_WALK_RD: begin
            cmd.walk_read = 1'b1;
            state_in      = S_WALK_EMIT;
         end
         S_WALK_EMIT: begin
            if (sts.out_free) begin
               cmd.walk_emit = 1'b1;
               state_in      = sts.walk_last ? S_IDLE : S_WALK_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/deq_dp.sv
module deq_dp
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ValueWidth-1:0]  push_value,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ValueWidth-1:0]  rsp_value,
   output logic [StatusWidth-1:0] rsp_status,
   output logic                   rsp_last
);

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [ValueWidth-1:0] mem [DEPTH];

   logic [SW-1:0]          front_ff, front_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SW-1:0]          walk_idx_ff, walk_idx_in;
   logic                   walk_back_ff, walk_back_in;
   logic [ValueWidth-1:0]  rdata_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0]  out_value_ff, out_value_in;
   logic [StatusWidth-1:0] out_status_ff, out_status_in;
   logic                   out_last_ff, out_last_in;

   logic [SW-1:0]          front_dec;
   logic [SW-1:0]          front_inc;
   logic [CW-1:0]          back_off;
   logic [SW-1:0]          rd_off;
   logic [SW:0]            rd_sum;
   logic [SW-1:0]          rd_addr;
   logic [SW:0]            wr_sum;
   logic [SW-1:0]          wr_addr;

   assign front_dec = (front_ff == '0) ? SW'(DEPTH - 1) : front_ff - SW'(1);
   assign front_inc = (front_ff == SW'(DEPTH - 1)) ? '0 : front_ff + SW'(1);

   // Walk offset from the front; a backward walk counts down from the back.
   assign back_off = count_ff - CW'(1) - CW'(walk_idx_ff);
   assign rd_off   = walk_back_ff ? back_off[SW-1:0] : walk_idx_ff;
   assign rd_sum   = (SW+1)'(front_ff) + (SW+1)'(rd_off);
   assign rd_addr  = (rd_sum >= (SW+1)'(DEPTH)) ? SW'(rd_sum - (SW+1)'(DEPTH))
                                                : rd_sum[SW-1:0];

   // Push to the back writes the slot just past the last element.
   assign wr_sum  = (SW+1)'(front_ff) + (SW+1)'(count_ff);
   assign wr_addr = cmd.push_front ? front_dec
                  : (wr_sum >= (SW+1)'(DEPTH)) ? SW'(wr_sum - (SW+1)'(DEPTH))
                                               : wr_sum[SW-1:0];

   assign sts.out_free  = !out_valid_ff || rsp_tready;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CW'(DEPTH));
   assign sts.walk_last = ((CW'(walk_idx_ff) + CW'(1)) == count_ff);

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      walk_idx_in  = walk_idx_ff;
      walk_back_in = walk_back_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end
      if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.walk_start) begin
         walk_idx_in  = '0;
         walk_back_in = cmd.walk_back;
      end
      if (cmd.walk_emit) begin
         walk_idx_in = walk_idx_ff + SW'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit_status) begin
         out_valid_in  = 1'b1;
         out_value_in  = '0;
         out_status_in = cmd.status;
         out_last_in   = 1'b1;
      end else if (cmd.walk_emit) begin
         out_valid_in  = 1'b1;
         out_value_in  = rdata_ff;
         out_status_in = ST_OK;
         out_last_in   = sts.walk_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_front || cmd.push_back) begin
         mem[wr_addr] <= push_value;
      end
      if (cmd.walk_read) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff   <= walk_idx_in;
      walk_back_ff  <= walk_back_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

endmodule

// File: hdl/double_ended_queue_engine.sv
// Channel   Direction  Contents
// req_      in         tdata[31:0] push_value, tuser[2:0] opcode
// rsp_      out        tdata[31:0] item_value, tuser[1:0] status, tlast last_of_run
//
// A push, a pop or an unused opcode leaves the controller idle; a push or pop result is loaded into
// the output register at its accepting edge, so these run at one item per cycle while
// rsp_tready stays high. A walk holds the input through its accepting cycle, then per
// entry through a registered store read and an output load, which a stalled result delays.
// Reset clears the front pointer, the count and the output valid flag; the store holds
// no reset value. A stalled result holds the output register and, through it, the input.
module double_ended_queue_engine
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] push_value
   input  logic [2:0]  req_tuser,  // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] item_value
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller decodes each item and sequences walks one entry at a time.
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath owns the circular store, its pointers and the output register.
   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   // A walk result is only loaded when the output register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_emit |-> sts.out_free)
      else $error("walk result loaded over a pending result");

   // A push never lands in a full store.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> !sts.full)
      else $error("push committed to a full store");

   // A pop never acts on an empty store.
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back) |-> !sts.empty)
      else $error("pop committed on an empty store");

   // No new item is taken while a walk is still reading the store.
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(cmd.walk_read || cmd.walk_emit))
      else $error("item taken during a walk");

endmodule

// File: dv/tb_double_ended_queue_engine.sv
module tb_double_ended_queue_engine;
   import deq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   // The two opcodes the block ignores without producing any result.
   localparam logic [2:0] OP_RESERVED_LO = 3'd6;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   // Number of useful (not ignored) items the random test sends.
   localparam int RANDOM_ITEMS = 470;

   // One expected result as it should appear on the rsp_ channel.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] item_value;
      logic        last_of_run;
   } deque_rsp_type;

   // Ready patterns of the result receiver.
   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_BURSTY
   } rsp_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // [31:0] push_value
   logic [2:0]  req_tuser  = '0;  // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] item_value
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        rsp_tlast;

   // Shadow copy of the queue, updated as each item is accepted.
   logic [31:0] deque_slots [DEPTH];
   int          front_idx = 0;
   int          occupancy = 0;

   // Results that the block still owes, oldest first.
   deque_rsp_type pending_results [$];

   // Sender and receiver pacing.
   int           burst_left     = 0;
   int           sender_gap_max = 0;
   rsp_mode_type rsp_mode       = RSP_ALWAYS;
   int           stall_left     = 0;

   // Bookkeeping for the summary and the verdict.
   int          error_count  = 0;
   int          items_sent   = 0;
   int          results_seen = 0;
   int          walk_count   = 0;
   int          full_hits    = 0;
   int          empty_hits   = 0;

   double_ended_queue_engine #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted item to the shadow queue and appends the results it
   // causes. A push or pop always answers once with last set; a walk answers
   // once per stored value, or once with the empty status when nothing is
   // stored. The unused opcodes change nothing and answer nothing.
   function automatic void predict_deque_results(logic [2:0] op, logic [31:0] val);
      deque_rsp_type rsp;
      int            pos;
      rsp = '{status: ST_OK, item_value: '0, last_of_run: 1'b1};
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (occupancy >= DEPTH) begin
               // A push to a full queue is dropped.
               rsp.status = ST_FULL;
               full_hits++;
            end else if (op == OP_PUSH_FRONT) begin
               front_idx = (front_idx + DEPTH - 1) % DEPTH;
               deque_slots[front_idx] = val;
               occupancy++;
            end else begin
               deque_slots[(front_idx + occupancy) % DEPTH] = val;
               occupancy++;
            end
            pending_results.push_back(rsp);
         end
         OP_WALK_FWD, OP_WALK_BWD: begin
            walk_count++;
            if (occupancy == 0) begin
               rsp.status = ST_EMPTY;
               empty_hits++;
               pending_results.push_back(rsp);
            end else begin
               // A backward walk of a single entry is an ordinary walk.
               for (int i = 0; i < occupancy; i++) begin
                  pos = (op == OP_WALK_FWD) ? i : occupancy - 1 - i;
                  rsp.item_value  = deque_slots[(front_idx + pos) % DEPTH];
                  rsp.last_of_run = (i == occupancy - 1);
                  pending_results.push_back(rsp);
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (occupancy == 0) begin
               rsp.status = ST_EMPTY;
               empty_hits++;
            end else begin
               if (op == OP_POP_FRONT) begin
                  front_idx = (front_idx + 1) % DEPTH;
               end
               occupancy--;
            end
            pending_results.push_back(rsp);
         end
         default: begin
            // Unused opcodes: no state change, no result.
         end
      endcase
   endfunction

   // Presents one item and waits for the block to take it. Items go out in
   // bursts; at the start of each burst the valid line may drop for a random
   // gap. Valid stays high from one item to the next within a burst, so it is
   // never lowered and raised in the same time step.
   task automatic send_item(input logic [2:0] op, input logic [31:0] val);
      if (burst_left == 0) begin
         if (sender_gap_max > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, sender_gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_deque_results(op, val);
      items_sent++;
      burst_left--;
   endtask

   // Result checker and receiver pacing. The handshake is judged on the values
   // seen at the edge; the ready for the next edge is then scheduled once.
   always @(posedge clock) begin
      deque_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("ERROR: unexpected result status=%0d value=%h last=%b",
                        rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata !== want.item_value ||
                rsp_tlast !== want.last_of_run) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result %0d expected status=%0d value=%h last=%b,",
                           results_seen, want.status, want.item_value,
                           want.last_of_run,
                           " got status=%0d value=%h last=%b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
      end

      case (rsp_mode)
         RSP_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         RSP_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 99) < 65);
         end
         default: begin
            // Mostly ready, with an occasional stall.
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_left = $urandom_range(1, 20);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Accesses on an empty queue: both pops, both walks, and the two
   // unused opcodes, which must leave no trace.
   task automatic test_empty_queue();
      sender_gap_max = 0;
      rsp_mode       = RSP_ALWAYS;
      send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
      send_item(OP_POP_BACK, 32'h0000_0000);
      send_item(OP_WALK_FWD, 32'h1234_5678);
      send_item(OP_RESERVED_LO, 32'hDEAD_BEEF);
      send_item(OP_WALK_BWD, 32'h8765_4321);
      send_item(OP_RESERVED_HI, 32'h0BAD_F00D);
   endtask

   // A single stored entry must come out of a backward walk as a normal value,
   // not as an empty queue.
   task automatic test_single_entry();
      sender_gap_max = 4;
      rsp_mode       = RSP_RANDOM;
      send_item(OP_PUSH_FRONT, 32'hC0DE_0001);
      send_item(OP_WALK_BWD, 32'h0000_0000);
      send_item(OP_POP_BACK, 32'h0000_0000);
   endtask

   // Fills the queue from both ends with extreme and striped values, pushes
   // twice more into the full queue, and walks it both ways.
   task automatic test_full_queue();
      logic [31:0] fill_values [8];
      fill_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
      sender_gap_max = 0;
      rsp_mode       = RSP_BURSTY;
      for (int i = 0; i < DEPTH; i++) begin
         send_item(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, fill_values[i % 8] ^ i);
      end
      send_item(OP_PUSH_FRONT, 32'h1111_1111);
      send_item(OP_PUSH_BACK, 32'h2222_2222);
      send_item(OP_WALK_FWD, 32'h0000_0000);
      send_item(OP_WALK_BWD, 32'h0000_0000);
   endtask

   // Random traffic in phases. Fill phases push more than they pop, drain
   // phases the reverse, and balanced phases hover in the middle, so the queue
   // keeps swinging between empty and full with the pointer wrapping around.
   // Each phase also picks its own sender gaps and receiver pattern.
   task automatic test_random_traffic();
      int          useful;
      int          phase_left;
      int          push_pct;
      int          pop_pct;
      int          pick;
      logic [2:0]  op;
      logic [31:0] val;
      useful     = 0;
      phase_left = 0;
      push_pct   = 40;
      pop_pct    = 40;
      while (useful < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       begin push_pct = 65; pop_pct = 15; end
               1:       begin push_pct = 15; pop_pct = 65; end
               default: begin push_pct = 40; pop_pct = 40; end
            endcase
            sender_gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            rsp_mode       = rsp_mode_type'($urandom_range(0, 2));
         end
         phase_left--;

         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else if (pick < push_pct + pop_pct) begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         end else if (pick < 95) begin
            op = $urandom_range(0, 1) ? OP_WALK_FWD : OP_WALK_BWD;
         end else begin
            op = $urandom_range(0, 1) ? OP_RESERVED_LO : OP_RESERVED_HI;
         end

         // Mostly full-range random values, with the extremes now and then.
         case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: val = $urandom();
         endcase

         send_item(op, val);
         if (op != OP_RESERVED_LO && op != OP_RESERVED_HI) begin
            useful++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_single_entry();
      test_full_queue();
      test_random_traffic();

      // Stop sending, let every owed result arrive, then keep watching for a
      // while so that a stray extra result is still caught.
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("tb: %0d items accepted, %0d results checked, %0d walks",
               items_sent, results_seen, walk_count);
      $display("tb: pushes into a full queue %0d, accesses on an empty queue %0d, errors %0d",
               full_hits, empty_hits, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Safety net well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue_engine.sv
dv/tb_double_ended_queue_engine.sv
